// ===== hw/rtl/rtcdsf_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcdsf_pkg
// Shared types, codes and calendar tables for the RTC date-set frame builder.
// ----------------------------------------------------------------------------
package rtcdsf_pkg;

  // Byte selection codes: frame positions, then the two error results
  localparam logic [3:0] SEL_ADDR   = 4'd0;
  localparam logic [3:0] SEL_SEC    = 4'd1;
  localparam logic [3:0] SEL_MIN    = 4'd2;
  localparam logic [3:0] SEL_HOUR   = 4'd3;
  localparam logic [3:0] SEL_WDAY   = 4'd4;
  localparam logic [3:0] SEL_DAY    = 4'd5;
  localparam logic [3:0] SEL_MON    = 4'd6;
  localparam logic [3:0] SEL_YEAR   = 4'd7;
  localparam logic [3:0] SEL_CTRL   = 4'd8;
  localparam logic [3:0] SEL_RANGE  = 4'd9;
  localparam logic [3:0] SEL_LEN    = 4'd10;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE_ERR = 2'd1;
  localparam logic [1:0] ST_LEN_ERR   = 2'd2;

  // Fixed frame bytes
  localparam logic [7:0] ADDR_BYTE = 8'h00;
  localparam logic [7:0] CTRL_BYTE = 8'h00;

  // Field limits
  localparam logic [7:0] MAX_SEC  = 8'd59;
  localparam logic [7:0] MAX_MIN  = 8'd59;
  localparam logic [7:0] MAX_HOUR = 8'd23;
  localparam logic [7:0] MAX_DAY  = 8'd31;
  localparam logic [7:0] MAX_MON  = 8'd12;
  localparam logic [7:0] MAX_YEAR = 8'd99;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       capture;
    logic       check;
    logic       wday;
    logic       load;
    logic [3:0] sel;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic range_err;
    logic len_err;
    logic last;
  } stat_t;

  // Days in month, indexed from January as 0 (non-leap year)
  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] len;
    unique case (idx)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days before the month, modulo 7, indexed from January as 0
  function automatic logic [2:0] cum_mod7(input logic [3:0] idx);
    logic [2:0] r;
    unique case (idx)
      4'd1, 4'd2, 4'd10:  r = 3'd3;
      4'd3, 4'd6:         r = 3'd6;
      4'd4:               r = 3'd1;
      4'd5:               r = 3'd4;
      4'd7:               r = 3'd2;
      4'd8, 4'd11:        r = 3'd5;
      default:            r = 3'd0;
    endcase
    return r;
  endfunction

  // Two-digit BCD of a value 0..99: tens by reciprocal multiply (205 / 2048)
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {8'd0, v} * 15'd205;
    tens = prod[14:11];
    ones = v - ({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

// ===== hw/rtl/rtcdsf_date_if.sv =====
// ----------------------------------------------------------------------------
// rtcdsf_date_if
// Valid/ready channel carrying one calendar date and time.
// ----------------------------------------------------------------------------
interface rtcdsf_date_if;
  logic       valid;
  logic       ready;
  logic [7:0] year_in;
  logic [7:0] month_in;
  logic [7:0] day_in;
  logic [7:0] hour_in;
  logic [7:0] minute_in;
  logic [7:0] second_in;

  modport source (
    output valid, year_in, month_in, day_in, hour_in, minute_in, second_in,
    input  ready
  );
  modport sink (
    input  valid, year_in, month_in, day_in, hour_in, minute_in, second_in,
    output ready
  );
endinterface

// ===== hw/rtl/rtcdsf_frame_if.sv =====
// ----------------------------------------------------------------------------
// rtcdsf_frame_if
// Valid/ready channel carrying one frame byte with its status and last mark.
// ----------------------------------------------------------------------------
interface rtcdsf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [1:0] status;
  logic       last_byte;

  modport source (
    output valid, frame_byte, status, last_byte,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, status, last_byte,
    output ready
  );
endinterface

// ===== hw/rtl/rtcdsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtcdsf_ctrl
// Controller: sequences capture, checking, weekday and the byte run.
// ----------------------------------------------------------------------------
module rtcdsf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rtcdsf_pkg::cmd_t    cmd,
  input  rtcdsf_pkg::stat_t   stat
);
  import rtcdsf_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state, state_next;
  logic [3:0] cnt, cnt_next;

  // Hold state and byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 4'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Decode state into commands and handshakes
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.wday = 1'b1;
        cmd.load = 1'b1;
        cnt_next = 4'd0;
        priority if (stat.range_err) begin
          cmd.sel = SEL_RANGE;
        end else if (stat.len_err) begin
          cmd.sel = SEL_LEN;
        end else begin
          cmd.sel = SEL_ADDR;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.load = 1'b1;
            cmd.sel  = cnt + 4'd1;
            cnt_next = cnt + 4'd1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/rtcdsf_datapath.sv =====
// ----------------------------------------------------------------------------
// rtcdsf_datapath
// Datapath: field registers, range and month-length checks, weekday and
// BCD output register.
// ----------------------------------------------------------------------------
module rtcdsf_datapath (
  input  logic              clk,
  input  logic [7:0]        year_in,
  input  logic [7:0]        month_in,
  input  logic [7:0]        day_in,
  input  logic [7:0]        hour_in,
  input  logic [7:0]        minute_in,
  input  logic [7:0]        second_in,
  input  rtcdsf_pkg::cmd_t  cmd,
  output rtcdsf_pkg::stat_t stat,
  output logic [7:0]        frame_byte,
  output logic [1:0]        status,
  output logic              last_byte
);
  import rtcdsf_pkg::*;

  logic [7:0] year, month, day, hour, minute, second;
  logic       range_err, len_err;
  logic [7:0] wsum;
  logic [2:0] wday;

  logic       range_bad;
  logic [3:0] mon_idx;
  logic       leap_year;
  logic [4:0] limit;
  logic [8:0] wsum_full;
  logic [13:0] wprod;
  logic [7:0] wrem;
  logic [2:0] wday_next;
  logic [7:0] byte_next;

  // Capture the date fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      year   <= year_in;
      month  <= month_in;
      day    <= day_in;
      hour   <= hour_in;
      minute <= minute_in;
      second <= second_in;
    end
  end

  // Range and month-length checks; weekday sum modulo-7 friendly
  // (365 is 1 mod 7, so whole years count as one day each)
  always_comb begin
    range_bad = (second > MAX_SEC) || (minute > MAX_MIN) || (hour > MAX_HOUR) ||
                (day == 8'd0) || (day > MAX_DAY) ||
                (month == 8'd0) || (month > MAX_MON) || (year > MAX_YEAR);
    mon_idx   = month[3:0] - 4'd1;
    leap_year = (year[1:0] == 2'd0);
    limit     = (mon_idx == 4'd1 && leap_year) ? 5'd29 : month_len(mon_idx);
    wsum_full = {1'b0, year} + {3'd0, 6'((year + 8'd3) >> 2)}
              + {6'd0, cum_mod7(mon_idx)}
              + {8'd0, (leap_year && month > 8'd2)}
              + {1'b0, day} + 9'd5;
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      range_err <= range_bad;
      len_err   <= (day > {3'd0, limit});
      wsum      <= wsum_full[7:0];
    end
  end

  // Reduce the weekday sum modulo 7: reciprocal estimate, one correction
  always_comb begin
    wprod = {6'd0, wsum} * 14'd36;
    wrem  = wsum - (wprod[13:8] * 8'd7);
    wday_next = (wrem >= 8'd7) ? 3'(wrem - 8'd7) : wrem[2:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.wday) begin
      wday <= wday_next;
    end
  end

  // Select the next frame byte
  always_comb begin
    unique case (cmd.sel)
      SEL_ADDR: byte_next = ADDR_BYTE;
      SEL_SEC:  byte_next = to_bcd(second[6:0]);
      SEL_MIN:  byte_next = to_bcd(minute[6:0]);
      SEL_HOUR: byte_next = to_bcd(hour[6:0]);
      SEL_WDAY: byte_next = to_bcd({4'd0, wday_next});
      SEL_DAY:  byte_next = to_bcd(day[6:0]);
      SEL_MON:  byte_next = to_bcd(month[6:0]);
      SEL_YEAR: byte_next = to_bcd(year[6:0]);
      SEL_CTRL: byte_next = CTRL_BYTE;
      default:  byte_next = 8'h00;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_byte <= (cmd.sel == SEL_WDAY) ? to_bcd({4'd0, wday}) : byte_next;
      status     <= (cmd.sel == SEL_RANGE) ? ST_RANGE_ERR :
                    (cmd.sel == SEL_LEN)   ? ST_LEN_ERR   : ST_OK;
      last_byte  <= (cmd.sel == SEL_CTRL) || (cmd.sel == SEL_RANGE) ||
                    (cmd.sel == SEL_LEN);
    end
  end

  assign stat.range_err = range_err;
  assign stat.len_err   = len_err;
  assign stat.last      = last_byte;

endmodule

// ===== hw/rtl/rtc_date_set_frame_builder_unit.sv =====
// ----------------------------------------------------------------------------
// rtc_date_set_frame_builder_unit
// Checks a calendar date and time and builds the nine-byte BCD date-set
// frame for a real-time clock, or one status result for a bad date.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  date     in   valid/ready   year_in, month_in, day_in, hour_in,
//                              minute_in, second_in
//  frame    out  valid/ready   frame_byte, status, last_byte
//
//  One item at a time: capture, check and weekday run as steps in that order,
//  then the result run leaves one byte a cycle while frame.ready is high. A
//  good date gives 9 bytes, a bad one gives 1 result.
//  Stalls on frame.ready hold the current byte; date.ready is high only
//  while no item is in progress. Synchronous reset returns to idle.
// ----------------------------------------------------------------------------
module rtc_date_set_frame_builder_unit (
  input  logic                  clk,
  input  logic                  rst,
  rtcdsf_date_if.sink           date,
  rtcdsf_frame_if.source        frame
);
  import rtcdsf_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [7:0] frame_byte;
  logic [1:0] status;
  logic       last_byte;

  rtcdsf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (date.valid),
    .in_ready  (date.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  rtcdsf_datapath u_datapath (
    .clk        (clk),
    .year_in    (date.year_in),
    .month_in   (date.month_in),
    .day_in     (date.day_in),
    .hour_in    (date.hour_in),
    .minute_in  (date.minute_in),
    .second_in  (date.second_in),
    .cmd        (cmd),
    .stat       (stat),
    .frame_byte (frame_byte),
    .status     (status),
    .last_byte  (last_byte)
  );

  // Drive the result channel payload
  assign frame.frame_byte = frame_byte;
  assign frame.status     = status;
  assign frame.last_byte  = last_byte;

endmodule
